// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_CLK(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("assertion failed");
`define ASSERT_NEVER(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_CLK(label, prop)
`define ASSERT_NEVER(label, expr)
`endif

`endif

// File: design/wmp_pkg.sv
// ----------------------------------------------------------------------------
// Waveform min/max pyramid package
// Shared widths, codes and record types of the min/max pyramid block.
// ----------------------------------------------------------------------------
package wmp_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int IDX_W     = 16;
	localparam int NB_W      = 17;
	localparam int FRAMES_W  = 32;
	localparam int CFG_IDX_W = 1;
	localparam int DIV_CNT_W = $clog2(FRAMES_W + 1);

	localparam logic [CFG_IDX_W-1:0] REG_BUCKET_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TOTAL_FRAMES = 1'd1;

	localparam logic REQ_SAMPLE = 1'b0;
	localparam logic REQ_DRAIN  = 1'b1;

	localparam logic signed [SAMPLE_W-1:0] Q_POS = 16'sh7FFF;
	localparam logic signed [SAMPLE_W-1:0] Q_NEG = 16'sh8000;

	localparam logic [NB_W-1:0]     NB_RESET     = 17'd1024;
	localparam logic [FRAMES_W-1:0] FRAMES_RESET = 32'd1;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	typedef struct packed {
		logic    valid;
		sample_t mn;
		sample_t mx;
	} link_t;

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		sample_t          mn;
		sample_t          mx;
	} res_t;

	typedef struct packed {
		logic            clear;
		logic [NB_W-1:0] nb;
	} cell_ctl_t;

endpackage

// File: design/wmp_div.sv
// ----------------------------------------------------------------------------
// Frames-per-bucket divider
// Restoring radix-2 divider, one quotient bit per cycle, restarted on request.
// ----------------------------------------------------------------------------
module wmp_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         restart,
	input  logic [wmp_pkg::FRAMES_W-1:0] dividend,
	input  logic [wmp_pkg::NB_W-1:0]     divisor,
	output logic                         busy,
	output logic [wmp_pkg::FRAMES_W-1:0] quotient
);

	logic                          pend_q;
	logic [wmp_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [wmp_pkg::NB_W-1:0]      dvs_q;
	logic [wmp_pkg::NB_W-1:0]      rem_q;
	logic [wmp_pkg::FRAMES_W-1:0]  quo_q;
	logic [wmp_pkg::NB_W:0]        trial;
	logic                          take;

	assign trial = {rem_q, quo_q[wmp_pkg::FRAMES_W-1]};
	assign take  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b1;
			cnt_q  <= '0;
		end else if (restart) begin
			pend_q <= 1'b1;
		end else if (pend_q) begin
			pend_q <= 1'b0;
			cnt_q  <= wmp_pkg::DIV_CNT_W'(wmp_pkg::FRAMES_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pend_q) begin
			dvs_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend;
		end else if (cnt_q != '0) begin
			rem_q <= take ? wmp_pkg::NB_W'(trial - {1'b0, dvs_q}) : trial[wmp_pkg::NB_W-1:0];
			quo_q <= {quo_q[wmp_pkg::FRAMES_W-2:0], take};
		end
	end

	assign busy     = pend_q || (cnt_q != '0);
	assign quotient = quo_q;

endmodule

// File: design/wmp_fine_cell.sv
// ----------------------------------------------------------------------------
// Finest-level bucket cell
// Collects samples into level-0 buckets and hands each closed bucket upward.
// ----------------------------------------------------------------------------
module wmp_fine_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  logic                         req_type,
	input  wmp_pkg::sample_t             sample,
	input  logic [wmp_pkg::NB_W-1:0]     nb,
	input  logic [wmp_pkg::FRAMES_W-1:0] total_frames,
	input  logic [wmp_pkg::FRAMES_W-1:0] div_quo,
	output logic                         run_idle,
	output logic                         close_final,
	output wmp_pkg::link_t               close,
	output wmp_pkg::res_t                res
);

	localparam logic [wmp_pkg::FRAMES_W-1:0] ONES = '1;

	logic [wmp_pkg::FRAMES_W-1:0] fpb_q;
	logic [wmp_pkg::FRAMES_W-1:0] sc_q;
	logic [wmp_pkg::FRAMES_W-1:0] ibc_q;
	logic [wmp_pkg::NB_W-1:0]     fine_q;
	wmp_pkg::sample_t             min_q;
	wmp_pkg::sample_t             max_q;

	logic [wmp_pkg::FRAMES_W-1:0] fpb;
	logic [wmp_pkg::FRAMES_W-1:0] sc_inc;
	logic [wmp_pkg::FRAMES_W-1:0] ibc_inc;
	logic                         is_final;
	logic                         do_close;
	wmp_pkg::sample_t             smin;
	wmp_pkg::sample_t             smax;
	wmp_pkg::sample_t             cmin;
	wmp_pkg::sample_t             cmax;

	always_comb begin
		run_idle = (fine_q == '0) && (ibc_q == '0);
		if (!run_idle) begin
			fpb = fpb_q;
		end else if (div_quo == '0) begin
			fpb = wmp_pkg::FRAMES_W'(1);
		end else begin
			fpb = div_quo;
		end
		is_final = fine_q >= (nb - 1'b1);
		smin     = (sample < min_q) ? sample : min_q;
		smax     = (sample > max_q) ? sample : max_q;
		sc_inc   = (sc_q == ONES) ? sc_q : sc_q + 1'b1;
		ibc_inc  = (ibc_q == ONES) ? ibc_q : ibc_q + 1'b1;
		if (req_type == wmp_pkg::REQ_DRAIN) begin
			do_close = 1'b1;
			cmin     = (ibc_q == '0) ? '0 : min_q;
			cmax     = (ibc_q == '0) ? '0 : max_q;
		end else begin
			do_close = (sc_inc >= total_frames) || (!is_final && (ibc_inc >= fpb));
			cmin     = smin;
			cmax     = smax;
		end
	end

	assign close.valid = accept && do_close;
	assign close.mn    = cmin;
	assign close.mx    = cmax;
	assign close_final = is_final;
	assign res.idx     = fine_q[wmp_pkg::IDX_W-1:0];
	assign res.mn      = cmin;
	assign res.mx      = cmax;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fpb_q  <= '0;
			sc_q   <= '0;
			ibc_q  <= '0;
			fine_q <= '0;
			min_q  <= wmp_pkg::Q_POS;
			max_q  <= wmp_pkg::Q_NEG;
		end else if (accept) begin
			if (run_idle) begin
				fpb_q <= fpb;
			end
			if (do_close) begin
				ibc_q <= '0;
				min_q <= wmp_pkg::Q_POS;
				max_q <= wmp_pkg::Q_NEG;
				if (is_final) begin
					sc_q   <= '0;
					fine_q <= '0;
				end else begin
					fine_q <= fine_q + 1'b1;
					if (req_type == wmp_pkg::REQ_SAMPLE) begin
						sc_q <= sc_inc;
					end
				end
			end else if (req_type == wmp_pkg::REQ_SAMPLE) begin
				sc_q  <= sc_inc;
				ibc_q <= ibc_inc;
				min_q <= smin;
				max_q <= smax;
			end
		end
	end

endmodule

// File: design/wmp_level_cell.sv
// ----------------------------------------------------------------------------
// Coarse-level merge cell
// Merges a group of child buckets into one bucket of the next coarser level.
// ----------------------------------------------------------------------------
module wmp_level_cell #(
	parameter int LEVEL             = 1,
	parameter int MERGE_FACTOR      = 4,
	parameter int MIN_LEVEL_BUCKETS = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  wmp_pkg::cell_ctl_t ctl,
	input  wmp_pkg::link_t     child,
	output wmp_pkg::link_t     parent,
	output wmp_pkg::res_t      res
);

	localparam int               CNT_W      = $clog2(MERGE_FACTOR);
	localparam logic [63:0]      DIV        = 64'(MERGE_FACTOR) ** LEVEL;
	localparam logic [63:0]      THR        = 64'(MIN_LEVEL_BUCKETS) * DIV;
	localparam logic [CNT_W-1:0] LAST_CHILD = CNT_W'(MERGE_FACTOR - 1);

	logic [CNT_W-1:0]         cnt_q;
	logic [wmp_pkg::IDX_W-1:0] idx_q;
	wmp_pkg::sample_t         min_q;
	wmp_pkg::sample_t         max_q;

	logic             present;
	logic             in_range;
	logic             take;
	logic             full;
	wmp_pkg::sample_t mmin;
	wmp_pkg::sample_t mmax;

	always_comb begin
		present  = 64'(ctl.nb) >= THR;
		in_range = ((64'(idx_q) + 64'd1) * DIV) <= 64'(ctl.nb);
		take     = child.valid && present && in_range;
		full     = cnt_q == LAST_CHILD;
		mmin     = (child.mn < min_q) ? child.mn : min_q;
		mmax     = (child.mx > max_q) ? child.mx : max_q;
	end

	assign parent.valid = take && full;
	assign parent.mn    = mmin;
	assign parent.mx    = mmax;
	assign res.idx      = idx_q;
	assign res.mn       = mmin;
	assign res.mx       = mmax;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
			min_q <= wmp_pkg::Q_POS;
			max_q <= wmp_pkg::Q_NEG;
		end else if (ctl.clear) begin
			cnt_q <= '0;
			idx_q <= '0;
			min_q <= wmp_pkg::Q_POS;
			max_q <= wmp_pkg::Q_NEG;
		end else if (take) begin
			if (full) begin
				cnt_q <= '0;
				idx_q <= idx_q + 1'b1;
				min_q <= wmp_pkg::Q_POS;
				max_q <= wmp_pkg::Q_NEG;
			end else begin
				cnt_q <= cnt_q + 1'b1;
				min_q <= mmin;
				max_q <= mmax;
			end
		end
	end

endmodule

// File: design/waveform_minmax_pyramid_top.sv
// A closing item's level-0 bucket is registered in the output or pending entry.
// Throughput: one item per cycle unless req_stall; an item that closes buckets
// then emits one result per cycle unless res_stall, so output transfers bound
// the rate when buckets close often. Reset and configuration writes restart the
// frames-per-bucket divider; a new run waits for it, items inside a run do not.
// Reset (arst_n, asynchronous, active low) clears the run and all merge cells.
// ----------------------------------------------------------------------------
// Waveform min/max pyramid top level
// Fine bucket cell and a chain of merge cells, with a two-entry result stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module waveform_minmax_pyramid_top #(
	parameter int MAX_BUCKETS       = 65536,
	parameter int MERGE_FACTOR      = 4,
	parameter int MIN_LEVEL_BUCKETS = 256,
	parameter int COARSE_LEVELS     = 4,
	localparam int LVL_W            = $clog2(COARSE_LEVELS + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [wmp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [wmp_pkg::FRAMES_W-1:0]  cfg_data,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic                          req_type,
	input  logic signed [15:0]            sample,
	output logic                          res_valid,
	input  logic                          res_stall,
	output logic [LVL_W-1:0]              level,
	output logic [15:0]                   bucket_index,
	output logic signed [15:0]            min_value,
	output logic signed [15:0]            max_value,
	output logic                          last
);

	localparam int NRES   = COARSE_LEVELS + 1;
	localparam int LEFT_W = $clog2(NRES + 1);

	logic [wmp_pkg::NB_W-1:0]     bucket_count_q;
	logic [wmp_pkg::FRAMES_W-1:0] total_frames_q;
	logic [wmp_pkg::NB_W-1:0]     nb;
	logic                         cfg_fire;
	logic                         div_busy;
	logic [wmp_pkg::FRAMES_W-1:0] div_quo;
	logic                         run_idle;
	logic                         close_final;
	logic                         accept;

	wmp_pkg::link_t     lk [NRES];
	wmp_pkg::res_t      new_b [NRES];
	wmp_pkg::cell_ctl_t ctl;
	logic [LEFT_W-1:0]  new_n;

	wmp_pkg::res_t     out_b_q [NRES];
	wmp_pkg::res_t     pend_b_q [NRES];
	logic [LEFT_W-1:0] out_left_q;
	logic [LEFT_W-1:0] pend_n_q;
	logic              pend_v_q;
	logic [LVL_W-1:0]  out_lvl_q;
	logic              fire_out;
	logic              out_free;
	logic              new_b_v;

	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_count_q <= wmp_pkg::NB_RESET;
			total_frames_q <= wmp_pkg::FRAMES_RESET;
		end else if (cfg_fire) begin
			unique case (cfg_index)
				wmp_pkg::REG_BUCKET_COUNT: begin
					bucket_count_q <= cfg_data[wmp_pkg::NB_W-1:0];
				end
				wmp_pkg::REG_TOTAL_FRAMES: begin
					total_frames_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		if (bucket_count_q == '0) begin
			nb = wmp_pkg::NB_W'(1);
		end else if (32'(bucket_count_q) > 32'(MAX_BUCKETS)) begin
			nb = wmp_pkg::NB_W'(MAX_BUCKETS);
		end else begin
			nb = bucket_count_q;
		end
	end

	wmp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.restart  (cfg_fire),
		.dividend (total_frames_q),
		.divisor  (nb),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	assign req_stall = pend_v_q || (run_idle && div_busy);
	assign accept    = req_valid && !req_stall;

	wmp_fine_cell u_fine (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.req_type     (req_type),
		.sample       (sample),
		.nb           (nb),
		.total_frames (total_frames_q),
		.div_quo      (div_quo),
		.run_idle     (run_idle),
		.close_final  (close_final),
		.close        (lk[0]),
		.res          (new_b[0])
	);

	assign ctl.clear = lk[0].valid && close_final;
	assign ctl.nb    = nb;

	for (genvar g = 0; g < COARSE_LEVELS; g++) begin : g_lvl
		wmp_level_cell #(
			.LEVEL             (g + 1),
			.MERGE_FACTOR      (MERGE_FACTOR),
			.MIN_LEVEL_BUCKETS (MIN_LEVEL_BUCKETS)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.child  (lk[g]),
			.parent (lk[g+1]),
			.res    (new_b[g+1])
		);
	end

	always_comb begin
		new_n = LEFT_W'(1);
		for (int k = 1; k < NRES; k++) begin
			new_n = new_n + LEFT_W'(lk[k].valid);
		end
	end

	assign new_b_v  = lk[0].valid;
	assign res_valid = out_left_q != '0;
	assign fire_out  = res_valid && !res_stall;
	assign out_free  = !res_valid || (fire_out && (out_left_q == LEFT_W'(1)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_left_q <= '0;
			out_lvl_q  <= '0;
			pend_v_q   <= 1'b0;
			pend_n_q   <= '0;
		end else if (out_free) begin
			out_lvl_q <= '0;
			if (pend_v_q) begin
				out_left_q <= pend_n_q;
				pend_v_q   <= new_b_v;
				pend_n_q   <= new_n;
			end else if (new_b_v) begin
				out_left_q <= new_n;
			end else begin
				out_left_q <= '0;
			end
		end else begin
			if (fire_out) begin
				out_left_q <= out_left_q - 1'b1;
				out_lvl_q  <= out_lvl_q + 1'b1;
			end
			if (new_b_v) begin
				pend_v_q <= 1'b1;
				pend_n_q <= new_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (pend_v_q) begin
				out_b_q  <= pend_b_q;
				pend_b_q <= new_b;
			end else begin
				out_b_q <= new_b;
			end
		end else begin
			if (fire_out) begin
				for (int k = 0; k < NRES - 1; k++) begin
					out_b_q[k] <= out_b_q[k+1];
				end
			end
			if (new_b_v) begin
				pend_b_q <= new_b;
			end
		end
	end

	assign level        = out_lvl_q;
	assign bucket_index = out_b_q[0].idx;
	assign min_value    = out_b_q[0].mn;
	assign max_value    = out_b_q[0].mx;
	assign last         = out_left_q == LEFT_W'(1);

	`ASSERT_CLK(a_pend_needs_out, pend_v_q |-> (out_left_q != '0))
	`ASSERT_CLK(a_new_run_waits_div, (req_valid && !req_stall && run_idle) |-> !div_busy)
	`ASSERT_NEVER(a_left_in_range, out_left_q > LEFT_W'(NRES))
	`ASSERT_NEVER(a_lvl_in_range, res_valid && ((32'(out_lvl_q) + 32'(out_left_q)) > 32'(NRES)))

endmodule
